/* rtl/core/pfx_pkg.sv */
// Shared types and header offsets for the packet header field extractor.
package pfx_pkg;

    localparam logic [15:0] ET_IPV4      = 16'h0800;
    localparam logic [15:0] ET_IPV6      = 16'h86DD;
    localparam logic [7:0]  PROTO_TCP    = 8'd6;
    localparam logic [7:0]  PROTO_UDP    = 8'd17;
    localparam logic [3:0]  IP4_GOOD_IHL = 4'd5;

    localparam logic [15:0] POS_ETYPE_HI = 16'd12;
    localparam logic [15:0] POS_ETYPE_LO = 16'd13;
    localparam logic [15:0] ETH_HDR_LEN  = 16'd14;
    localparam logic [15:0] IP4_HDR_LEN  = 16'd20;
    localparam logic [15:0] IP6_HDR_LEN  = 16'd40;
    localparam logic [15:0] TCP_HDR_LEN  = 16'd20;
    localparam logic [15:0] UDP_HDR_LEN  = 16'd8;
    localparam logic [15:0] L4_OFF_IP4   = ETH_HDR_LEN + IP4_HDR_LEN;
    localparam logic [15:0] L4_OFF_IP6   = ETH_HDR_LEN + IP6_HDR_LEN;
    localparam logic [15:0] LEN_MAX      = 16'hFFFF;

    // offsets inside the IPv4 header
    localparam logic [15:0] IP4_VER_IHL  = 16'd0;
    localparam logic [15:0] IP4_PROTO    = 16'd9;
    localparam logic [15:0] IP4_SRC      = 16'd12;
    localparam logic [15:0] IP4_DST      = 16'd16;
    // offsets inside the IPv6 header
    localparam logic [15:0] IP6_NEXT_HDR = 16'd6;
    localparam logic [15:0] IP6_SRC_HI   = 16'd8;
    localparam logic [15:0] IP6_SRC_LO   = 16'd16;
    localparam logic [15:0] IP6_DST_HI   = 16'd24;
    localparam logic [15:0] IP6_DST_LO   = 16'd32;
    // offsets inside the TCP/UDP header
    localparam logic [15:0] L4_SPORT_HI  = 16'd0;
    localparam logic [15:0] L4_SPORT_LO  = 16'd1;
    localparam logic [15:0] L4_DPORT_HI  = 16'd2;
    localparam logic [15:0] L4_DPORT_LO  = 16'd3;
    localparam logic [15:0] L4_SEQ       = 16'd4;
    localparam logic [15:0] L4_SEQ_END   = 16'd8;

    typedef struct packed {
        logic [15:0] ether_type;
        logic [7:0]  ip_proto;
        logic [63:0] src_high;
        logic [63:0] src_low;
        logic [63:0] dst_high;
        logic [63:0] dst_low;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [31:0] seq;
        logic        ihl_bad;
    } t_hdr;

    // first field in the highest bits
    typedef struct packed {
        logic [15:0] payload_length;
        logic [15:0] packet_length;
        logic [31:0] sequence_res;
        logic [15:0] port_dst;
        logic [15:0] port_src;
        logic [63:0] dst_low;
        logic [63:0] dst_high;
        logic [63:0] src_low;
        logic [63:0] src_high;
        logic [7:0]  l4_type;
        logic [15:0] l3_type;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

endpackage

/* rtl/core/pfx_capture.sv */
// Per-byte header field capture: byte counter and captured header fields.
module pfx_capture
    import pfx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    output t_hdr        o_hdr,
    output logic [15:0] o_len
);

    logic [15:0] r_pos;
    logic [15:0] n_pos;
    t_hdr        r_hdr;
    t_hdr        n_hdr;
    logic [15:0] rel;
    logic [15:0] l4_off;
    logic [15:0] l4_rel;
    logic        is_v4;
    logic        is_v6;

    // replace byte k (0 = most significant) of a 64-bit word
    function automatic logic [63:0] put_byte(logic [63:0] w, logic [2:0] k, logic [7:0] b);
        logic [63:0] r;
        r = w;
        for (int i = 0; i < 8; i++) begin
            if (k == 3'(i)) begin
                r[8*(7-i) +: 8] = b;
            end
        end
        return r;
    endfunction

    assign is_v4  = (r_hdr.ether_type == ET_IPV4);
    assign is_v6  = (r_hdr.ether_type == ET_IPV6);
    assign rel    = r_pos - ETH_HDR_LEN;
    assign l4_off = is_v4 ? L4_OFF_IP4 : (is_v6 ? L4_OFF_IP6 : ETH_HDR_LEN);
    assign l4_rel = r_pos - l4_off;
    assign n_pos  = (r_pos != LEN_MAX) ? r_pos + 16'd1 : LEN_MAX;

    always_comb begin
        n_hdr = r_hdr;
        if (r_pos == POS_ETYPE_HI) begin
            n_hdr.ether_type = {i_byte, 8'h00};
        end else if (r_pos == POS_ETYPE_LO) begin
            n_hdr.ether_type[7:0] = i_byte;
        end else if (r_pos < ETH_HDR_LEN) begin
            n_hdr = r_hdr;
        end else if (is_v4 && r_pos < L4_OFF_IP4) begin
            if (rel == IP4_VER_IHL) begin
                n_hdr.ihl_bad = (i_byte[3:0] != IP4_GOOD_IHL);
            end else if (rel == IP4_PROTO) begin
                n_hdr.ip_proto = i_byte;
            end else if (rel >= IP4_SRC && rel < IP4_DST) begin
                n_hdr.src_high = put_byte(r_hdr.src_high, {1'b0, rel[1:0]}, i_byte);
            end else if (rel >= IP4_DST) begin
                n_hdr.dst_high = put_byte(r_hdr.dst_high, {1'b0, rel[1:0]}, i_byte);
            end
        end else if (is_v6 && r_pos < L4_OFF_IP6) begin
            if (rel == IP6_NEXT_HDR) begin
                n_hdr.ip_proto = i_byte;
            end else if (rel >= IP6_SRC_HI && rel < IP6_SRC_LO) begin
                n_hdr.src_high = put_byte(r_hdr.src_high, rel[2:0], i_byte);
            end else if (rel >= IP6_SRC_LO && rel < IP6_DST_HI) begin
                n_hdr.src_low = put_byte(r_hdr.src_low, rel[2:0], i_byte);
            end else if (rel >= IP6_DST_HI && rel < IP6_DST_LO) begin
                n_hdr.dst_high = put_byte(r_hdr.dst_high, rel[2:0], i_byte);
            end else if (rel >= IP6_DST_LO) begin
                n_hdr.dst_low = put_byte(r_hdr.dst_low, rel[2:0], i_byte);
            end
        end else if (r_pos >= l4_off &&
                     (r_hdr.ip_proto == PROTO_TCP || r_hdr.ip_proto == PROTO_UDP)) begin
            if (l4_rel == L4_SPORT_HI) begin
                n_hdr.sport = {i_byte, 8'h00};
            end else if (l4_rel == L4_SPORT_LO) begin
                n_hdr.sport[7:0] = i_byte;
            end else if (l4_rel == L4_DPORT_HI) begin
                n_hdr.dport = {i_byte, 8'h00};
            end else if (l4_rel == L4_DPORT_LO) begin
                n_hdr.dport[7:0] = i_byte;
            end else if (r_hdr.ip_proto == PROTO_TCP && l4_rel >= L4_SEQ &&
                         l4_rel < L4_SEQ_END) begin
                case (l4_rel[1:0])
                    2'd0:    n_hdr.seq[31:24] = i_byte;
                    2'd1:    n_hdr.seq[23:16] = i_byte;
                    2'd2:    n_hdr.seq[15:8]  = i_byte;
                    default: n_hdr.seq[7:0]   = i_byte;
                endcase
            end
        end
    end

    // state is wiped after every final byte, kept or dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_hdr <= '0;
        end else if (i_accept) begin
            if (i_last) begin
                r_pos <= '0;
                r_hdr <= '0;
            end else begin
                r_pos <= n_pos;
                r_hdr <= n_hdr;
            end
        end
    end

    assign o_hdr = n_hdr;
    assign o_len = n_pos;

`ifndef ASSERT_OFF
    a_pos_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_last |=> r_pos == 16'd0 && r_hdr == '0)
        else $error("byte position not cleared after final byte");

    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && !i_last && r_pos != LEN_MAX |=> r_pos == $past(r_pos) + 16'd1)
        else $error("byte position did not advance by one");
`endif

endmodule

/* rtl/core/pfx_result.sv */
// Completeness check and length arithmetic that form the metadata record.
module pfx_result
    import pfx_pkg::*;
(
    input  t_hdr        i_hdr,
    input  logic [15:0] i_len,
    output logic        o_ok,
    output t_result     o_result
);

    logic [15:0] l3_end;
    logic [15:0] hdr_len;
    logic        is_v4;
    logic        is_v6;
    logic        l3_ok;

    assign is_v4  = (i_hdr.ether_type == ET_IPV4);
    assign is_v6  = (i_hdr.ether_type == ET_IPV6);
    assign l3_end = is_v4 ? L4_OFF_IP4 : (is_v6 ? L4_OFF_IP6 : ETH_HDR_LEN);

    always_comb begin
        l3_ok = 1'b1;
        if (i_len < ETH_HDR_LEN) begin
            l3_ok = 1'b0;
        end else if (is_v4 && (i_len < l3_end || i_hdr.ihl_bad)) begin
            l3_ok = 1'b0;
        end else if (is_v6 && i_len < l3_end) begin
            l3_ok = 1'b0;
        end
    end

    always_comb begin
        hdr_len = l3_end;
        o_ok    = l3_ok;
        if (l3_ok && i_hdr.ip_proto == PROTO_TCP) begin
            hdr_len = l3_end + TCP_HDR_LEN;
            o_ok    = (i_len >= hdr_len);
        end else if (l3_ok && i_hdr.ip_proto == PROTO_UDP) begin
            hdr_len = l3_end + UDP_HDR_LEN;
            o_ok    = (i_len >= hdr_len);
        end
    end

    always_comb begin
        o_result.l3_type        = i_hdr.ether_type;
        o_result.l4_type        = i_hdr.ip_proto;
        o_result.src_high       = i_hdr.src_high;
        o_result.src_low        = i_hdr.src_low;
        o_result.dst_high       = i_hdr.dst_high;
        o_result.dst_low        = i_hdr.dst_low;
        o_result.port_src       = i_hdr.sport;
        o_result.port_dst       = i_hdr.dport;
        o_result.sequence_res   = i_hdr.seq;
        o_result.packet_length  = i_len;
        o_result.payload_length = i_len - hdr_len;
    end

endmodule

/* rtl/core/pfx_obuf.sv */
// Result register with a skid entry so input bytes keep flowing while a record waits.
module pfx_obuf
    import pfx_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    input  logic    i_ready,
    output logic    o_valid,
    output t_result o_data,
    output logic    o_space
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    pop;

    assign pop = r_out_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (r_out_valid && !pop) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (r_out_valid && !pop) begin
                r_skid <= i_data;
            end else begin
                r_out <= i_data;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign o_space = !r_skid_valid;

`ifndef ASSERT_OFF
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while result register empty");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !r_skid_valid)
        else $error("record pushed into a full buffer");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && pop |=> r_out_valid && !r_skid_valid)
        else $error("skid entry not moved into result register");
`endif

endmodule

/* rtl/core/packet_header_field_extractor.sv */
// Accepting a complete packet's final byte registers its record into the result buffer.
// Throughput: one packet byte per cycle; the byte counter and field capture registers
// update every transaction, and a two-entry result buffer holds ready low only while
// two records wait downstream. Synchronous active-low reset clears the parser and buffer.
// Top level: Ethernet/IPv4/IPv6/TCP/UDP header field extractor.
module packet_header_field_extractor
    import pfx_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [7:0]          i_s_axis_tdata,   // data_byte
    input  logic                i_s_axis_tlast,   // last_byte
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // l3_type, l4_type, src_high, src_low, dst_high, dst_low, port_src, port_dst,
    // sequence_res, packet_length, payload_length
    output logic [RESULT_W-1:0] o_m_axis_tdata
);

    logic        accept;
    logic        ok;
    t_hdr        hdr;
    logic [15:0] len;
    t_result     result;
    t_result     out_data;

    assign accept = i_s_axis_tvalid && o_s_axis_tready;

    pfx_capture u_capture (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_s_axis_tdata),
        .i_last   (i_s_axis_tlast),
        .o_hdr    (hdr),
        .o_len    (len)
    );

    pfx_result u_result (
        .i_hdr    (hdr),
        .i_len    (len),
        .o_ok     (ok),
        .o_result (result)
    );

    pfx_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && i_s_axis_tlast && ok),
        .i_data  (result),
        .i_ready (i_m_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_data  (out_data),
        .o_space (o_s_axis_tready)
    );

    assign o_m_axis_tdata = out_data;

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the packet header field extractor stream block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import pfx_pkg::*;

    localparam longint CYCLE_LIMIT  = 3_000_000;
    localparam int     HOLD_CYCLES  = 400;
    localparam int     RAND_BYTES   = 1800;
    localparam int     RAND_RECORDS = 48;
    localparam int     LONG_PAYLOAD = 66000;
    localparam logic [7:0] PROTO_ICMP  = 8'd1;
    localparam logic [7:0] PROTO_NO_NH = 8'd59;

    typedef enum int {FK_NOISE, FK_NONIP, FK_IPV4, FK_IPV6} t_frame_kind;
    typedef enum int {FILL_RAND, FILL_ZERO, FILL_ONES} t_fill;

    // Mirrors the parser state byte by byte and queues the metadata record each frame yields.
    class t_hdr_scoreboard;
        bit [15:0] frame_bytes;
        bit [15:0] etype;
        bit [7:0]  proto;
        bit [63:0] src_words[2];
        bit [63:0] dst_words[2];
        bit [15:0] sport;
        bit [15:0] dport;
        bit [31:0] seq_no;
        bit        ihl_bad;
        t_result   pending_records[$];
        int        errors;
        int        bytes_in;
        int        frames_in;
        int        records_made;
        int        records_checked;
        int        frames_dropped;

        function void restart_frame();
            frame_bytes  = '0;
            etype        = '0;
            proto        = '0;
            src_words[0] = '0;
            src_words[1] = '0;
            dst_words[0] = '0;
            dst_words[1] = '0;
            sport        = '0;
            dport        = '0;
            seq_no       = '0;
            ihl_bad      = 1'b0;
        endfunction

        function new();
            restart_frame();
        endfunction

        function int l4_base();
            if (etype == ET_IPV4) return L4_OFF_IP4;
            if (etype == ET_IPV6) return L4_OFF_IP6;
            return ETH_HDR_LEN;
        endfunction

        // k = 0 is the most significant byte of the 128-bit address
        function void put_addr(bit to_dst, int k, bit [7:0] b);
            int w;
            int sh;
            w  = (k >> 3) & 1;
            sh = 8 * (7 - (k & 7));
            if (to_dst) dst_words[w] |= 64'(b) << sh;
            else src_words[w] |= 64'(b) << sh;
        endfunction

        function void parse_byte(int pos, bit [7:0] b);
            int r;
            int base;
            if (pos == POS_ETYPE_HI) begin
                etype = {b, 8'h00};
                return;
            end
            if (pos == POS_ETYPE_LO) begin
                etype[7:0] = b;
                return;
            end
            if (pos < ETH_HDR_LEN) return;
            if (etype == ET_IPV4 && pos < L4_OFF_IP4) begin
                r = pos - ETH_HDR_LEN;
                if (r == IP4_VER_IHL) ihl_bad = (b[3:0] != IP4_GOOD_IHL);
                else if (r == IP4_PROTO) proto = b;
                else if (r >= IP4_SRC && r < IP4_DST) put_addr(1'b0, r - IP4_SRC, b);
                else if (r >= IP4_DST && r < IP4_HDR_LEN) put_addr(1'b1, r - IP4_DST, b);
                return;
            end
            if (etype == ET_IPV6 && pos < L4_OFF_IP6) begin
                r = pos - ETH_HDR_LEN;
                if (r == IP6_NEXT_HDR) proto = b;
                else if (r >= IP6_SRC_HI && r < IP6_DST_HI) put_addr(1'b0, r - IP6_SRC_HI, b);
                else if (r >= IP6_DST_HI && r < IP6_HDR_LEN) put_addr(1'b1, r - IP6_DST_HI, b);
                return;
            end
            base = l4_base();
            if (pos < base) return;
            if (proto == PROTO_TCP || proto == PROTO_UDP) begin
                r = pos - base;
                if (r == L4_SPORT_HI) sport = {b, 8'h00};
                else if (r == L4_SPORT_LO) sport[7:0] = b;
                else if (r == L4_DPORT_HI) dport = {b, 8'h00};
                else if (r == L4_DPORT_LO) dport[7:0] = b;
                else if (proto == PROTO_TCP && r >= L4_SEQ && r < L4_SEQ_END)
                    seq_no |= 32'(b) << (8 * (7 - r));
            end
        endfunction

        function void note_byte(bit [7:0] b, bit last);
            int      hdr;
            bit      ok;
            t_result rec;
            parse_byte(frame_bytes, b);
            if (frame_bytes != LEN_MAX) frame_bytes++;
            bytes_in++;
            if (!last) return;
            frames_in++;
            hdr = l4_base();
            ok  = 1'b1;
            if (frame_bytes < ETH_HDR_LEN) ok = 1'b0;
            else if (etype == ET_IPV4 && (frame_bytes < hdr || ihl_bad)) ok = 1'b0;
            else if (etype == ET_IPV6 && frame_bytes < hdr) ok = 1'b0;
            if (ok && proto == PROTO_TCP) begin
                hdr += TCP_HDR_LEN;
                ok = (frame_bytes >= hdr);
            end else if (ok && proto == PROTO_UDP) begin
                hdr += UDP_HDR_LEN;
                ok = (frame_bytes >= hdr);
            end
            if (ok) begin
                rec.l3_type        = etype;
                rec.l4_type        = proto;
                rec.src_high       = src_words[0];
                rec.src_low        = src_words[1];
                rec.dst_high       = dst_words[0];
                rec.dst_low        = dst_words[1];
                rec.port_src       = sport;
                rec.port_dst       = dport;
                rec.sequence_res   = seq_no;
                rec.packet_length  = frame_bytes;
                rec.payload_length = 16'(frame_bytes - hdr);
                pending_records.push_back(rec);
                records_made++;
            end else begin
                frames_dropped++;
            end
            restart_frame();
        endfunction

        function void cmp(string name, logic [63:0] want_v, logic [63:0] got_v);
            if (got_v !== want_v) begin
                errors++;
                $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, want_v, got_v);
            end
        endfunction

        function void check_record(t_result got);
            t_result want;
            if (pending_records.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected record, expected none actual %h", $time, got);
                return;
            end
            want = pending_records.pop_front();
            records_checked++;
            cmp("l3_type",        want.l3_type,        got.l3_type);
            cmp("l4_type",        want.l4_type,        got.l4_type);
            cmp("src_high",       want.src_high,       got.src_high);
            cmp("src_low",        want.src_low,        got.src_low);
            cmp("dst_high",       want.dst_high,       got.dst_high);
            cmp("dst_low",        want.dst_low,        got.dst_low);
            cmp("port_src",       want.port_src,       got.port_src);
            cmp("port_dst",       want.port_dst,       got.port_dst);
            cmp("sequence_res",   want.sequence_res,   got.sequence_res);
            cmp("packet_length",  want.packet_length,  got.packet_length);
            cmp("payload_length", want.payload_length, got.payload_length);
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                s_valid;
    logic                s_ready;
    logic [7:0]          s_data;
    logic                s_last;
    logic                m_valid;
    logic                m_ready;
    logic [RESULT_W-1:0] m_data;

    t_hdr_scoreboard book;
    bit [7:0]        frame_q[$];
    bit              sender_idle_on;
    bit              sink_idle_on;
    bit              hold_req;
    longint          cycles;

    packet_header_field_extractor uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),     // data_byte
        .i_s_axis_tlast  (s_last),     // last_byte
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        // l3_type, l4_type, src_high, src_low, dst_high, dst_low, port_src, port_dst,
        // sequence_res, packet_length, payload_length
        .o_m_axis_tdata  (m_data)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        cycles = 0;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t ns: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_valid && m_ready) book.check_record(t_result'(m_data));
    end

    // Downstream side: random stalls, plus one long hold-off on request.
    initial begin
        int hold_left;
        int stall_left;
        bit hold_done;
        hold_left  = 0;
        stall_left = 0;
        hold_done  = 1'b0;
        m_ready    = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 11) == 0) begin
                stall_left = $urandom_range(1, 19) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic bit [7:0] fill_byte(t_fill fill);
        case (fill)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hFF;
            default:   return 8'($urandom);
        endcase
    endfunction

    task automatic send_byte(input bit [7:0] b, input bit last);
        int gap;
        @(negedge clk);
        if (sender_idle_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 19);
            s_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        s_last  <= last;
        do @(posedge clk); while (!s_ready);
        book.note_byte(b, last);
    endtask

    // Builds a frame (headers with the given fill, then payload), drops up to short_by bytes
    // off its end while keeping at least one, and streams it as one byte per transaction.
    task automatic run_frame(input t_frame_kind kind, input bit [7:0] l4p, input bit [3:0] ihl,
                             input int pay, input t_fill fill, input int short_by);
        bit [15:0] et;
        int        i;
        frame_q.delete();
        if (kind == FK_NOISE) begin
            repeat (pay) frame_q.push_back(fill_byte(fill));
        end else begin
            repeat (12) frame_q.push_back(fill_byte(fill));
            case (kind)
                FK_IPV4: et = ET_IPV4;
                FK_IPV6: et = ET_IPV6;
                default: begin
                    et = {fill_byte(fill), fill_byte(fill)};
                    if (et == ET_IPV4 || et == ET_IPV6) et = ~et;
                end
            endcase
            frame_q.push_back(et[15:8]);
            frame_q.push_back(et[7:0]);
            if (kind == FK_IPV4) begin
                frame_q.push_back({4'd4, ihl});
                repeat (8) frame_q.push_back(fill_byte(fill));
                frame_q.push_back(l4p);
                repeat (10) frame_q.push_back(fill_byte(fill));
            end else if (kind == FK_IPV6) begin
                repeat (6) frame_q.push_back(fill_byte(fill));
                frame_q.push_back(l4p);
                repeat (33) frame_q.push_back(fill_byte(fill));
            end
            if (kind == FK_IPV4 || kind == FK_IPV6) begin
                if (l4p == PROTO_TCP) repeat (TCP_HDR_LEN) frame_q.push_back(fill_byte(fill));
                else if (l4p == PROTO_UDP) repeat (UDP_HDR_LEN) frame_q.push_back(fill_byte(fill));
            end
            repeat (pay) frame_q.push_back(fill_byte(fill));
        end
        for (i = 0; i < short_by && frame_q.size() > 1; i++) void'(frame_q.pop_back());
        for (i = 0; i < frame_q.size(); i++) send_byte(frame_q[i], i == frame_q.size() - 1);
    endtask

    task automatic random_frame();
        int          pick;
        int          pay;
        int          short_by;
        bit [7:0]    l4p;
        bit [3:0]    ihl;
        t_frame_kind kind;
        pick = $urandom_range(0, 19);
        if (pick < 9) l4p = PROTO_TCP;
        else if (pick < 17) l4p = PROTO_UDP;
        else l4p = 8'($urandom);
        pay      = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 24);
        ihl      = IP4_GOOD_IHL;
        short_by = 0;
        pick     = $urandom_range(0, 99);
        if (pick < 30) begin
            kind = FK_IPV4;
        end else if (pick < 55) begin
            kind = FK_IPV6;
        end else if (pick < 65) begin
            kind = FK_NONIP;
        end else if (pick < 72) begin
            kind = FK_IPV4;
            ihl  = 4'(IP4_GOOD_IHL + $urandom_range(1, 15));
        end else if (pick < 87) begin
            // broken frame: cut somewhere in the headers or the first payload bytes
            kind     = t_frame_kind'($urandom_range(FK_NONIP, FK_IPV6));
            pay      = $urandom_range(0, 4);
            short_by = $urandom_range(1, 30);
        end else begin
            kind = FK_NOISE;
            pay  = $urandom_range(1, 70);
        end
        run_frame(kind, l4p, ihl, pay, FILL_RAND, short_by);
    endtask

    initial begin
        int start_bytes;
        int start_recs;
        int frame_no;
        book           = new();
        rst_n          = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        s_last         = 1'b0;
        hold_req       = 1'b0;
        sender_idle_on = 1'b1;
        sink_idle_on   = 1'b1;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed frames: extremes, each protocol mix, short frames at several header boundaries
        run_frame(FK_NOISE, PROTO_TCP,   IP4_GOOD_IHL, 1,  FILL_ONES, 0);
        run_frame(FK_NONIP, PROTO_TCP,   IP4_GOOD_IHL, 0,  FILL_RAND, 1);
        run_frame(FK_NONIP, PROTO_TCP,   IP4_GOOD_IHL, 0,  FILL_ZERO, 0);
        run_frame(FK_NONIP, PROTO_TCP,   IP4_GOOD_IHL, 5,  FILL_ONES, 0);
        run_frame(FK_IPV4,  PROTO_TCP,   IP4_GOOD_IHL, 0,  FILL_ONES, 0);
        run_frame(FK_IPV4,  PROTO_TCP,   IP4_GOOD_IHL, 0,  FILL_RAND, 1);
        run_frame(FK_IPV4,  PROTO_TCP,   IP4_GOOD_IHL, 0,  FILL_RAND, 34);
        run_frame(FK_IPV4,  PROTO_UDP,   IP4_GOOD_IHL, 3,  FILL_ZERO, 0);
        run_frame(FK_IPV4,  PROTO_UDP,   IP4_GOOD_IHL, 0,  FILL_RAND, 1);
        run_frame(FK_IPV4,  PROTO_ICMP,  IP4_GOOD_IHL, 4,  FILL_RAND, 0);
        run_frame(FK_IPV4,  PROTO_ICMP,  IP4_GOOD_IHL, 0,  FILL_RAND, 1);
        run_frame(FK_IPV4,  PROTO_TCP,   4'd6,         8,  FILL_RAND, 0);
        run_frame(FK_IPV4,  PROTO_UDP,   4'd0,         2,  FILL_ZERO, 0);
        run_frame(FK_IPV6,  PROTO_TCP,   IP4_GOOD_IHL, 0,  FILL_ONES, 0);
        run_frame(FK_IPV6,  PROTO_TCP,   IP4_GOOD_IHL, 0,  FILL_RAND, 1);
        run_frame(FK_IPV6,  PROTO_UDP,   IP4_GOOD_IHL, 2,  FILL_ZERO, 0);
        run_frame(FK_IPV6,  PROTO_UDP,   IP4_GOOD_IHL, 0,  FILL_RAND, 1);
        run_frame(FK_IPV6,  PROTO_NO_NH, IP4_GOOD_IHL, 1,  FILL_RAND, 0);
        run_frame(FK_IPV6,  PROTO_NO_NH, IP4_GOOD_IHL, 0,  FILL_RAND, 1);

        // length counter saturation
        sender_idle_on = 1'b0;
        sink_idle_on   = 1'b0;
        run_frame(FK_IPV4, PROTO_TCP, IP4_GOOD_IHL, LONG_PAYLOAD, FILL_RAND, 0);

        // back-pressure: downstream holds off while minimal frames keep coming
        hold_req = 1'b1;
        repeat (12) run_frame(FK_NONIP, PROTO_TCP, IP4_GOOD_IHL, 0, FILL_RAND, 0);

        start_bytes = book.bytes_in;
        start_recs  = book.records_made;
        frame_no    = 0;
        while (book.bytes_in - start_bytes < RAND_BYTES ||
               book.records_made - start_recs < RAND_RECORDS) begin
            sender_idle_on = (frame_no % 12 < 9) &&
                             (book.bytes_in - start_bytes < RAND_BYTES * 4 / 5);
            sink_idle_on   = sender_idle_on;
            random_frame();
            frame_no++;
        end

        @(negedge clk);
        s_valid <= 1'b0;
        while (book.pending_records.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("covered %0d frames in %0d byte transactions: %0d records checked, %0d dropped",
                 book.frames_in, book.bytes_in, book.records_checked, book.frames_dropped);
        $display("including a frame past the 16-bit length limit and a %0d-cycle output hold-off",
                 HOLD_CYCLES);
        if (book.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", book.errors);
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/pfx_pkg.sv
rtl/core/pfx_capture.sv
rtl/core/pfx_result.sv
rtl/core/pfx_obuf.sv
rtl/core/packet_header_field_extractor.sv
sim/testbench.sv
